// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed: invariant");

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/utd_pkg.sv
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int PEND_W = 2;

    // Lead byte classification limits
    localparam logic [BYTE_W-1:0] ASCII_LIMIT     = 8'h80;
    localparam logic [BYTE_W-1:0] THREE_BYTE_LEAD = 8'h80 + 8'h40 + 8'h20;

    // Continuation bytes still expected
    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [PEND_W-1:0] pend;
        logic [UNIT_W-1:0] acc;
    } t_state;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              stream_done;
        logic              truncated;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_state  next;
        t_result res;
    } t_step;

endpackage

// File: sv/utd_in_reg.sv
// ----------------------------------------------------------------------------
// utd_in_reg
// Input register: while ready, captures one byte per cycle and holds it until consumed.
// ----------------------------------------------------------------------------
module utd_in_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [utd_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] byte_in
    input  logic                         s_axis_tlast,   // end_of_stream
    input  logic                         i_pop,
    output logic                         o_vld,
    output logic [utd_pkg::BYTE_W-1:0]   o_byte,
    output logic                         o_last
);

    logic                       r_vld;
    logic [utd_pkg::BYTE_W-1:0] r_byte;
    logic                       r_last;

    assign s_axis_tready = !r_vld || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_vld <= 1'b1;
        end else if (i_pop) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;
    assign o_last = r_last;

endmodule

// File: sv/utd_decode.sv
// ----------------------------------------------------------------------------
// utd_decode
// Per-byte decode step: next sequence state and the code unit, if any.
// ----------------------------------------------------------------------------
module utd_decode (
    input  utd_pkg::t_state              i_state,
    input  logic [utd_pkg::BYTE_W-1:0]   i_byte,
    input  logic                         i_last,
    output utd_pkg::t_step               o_step
);

    utd_pkg::t_state             w_acc;
    logic                        w_emit;
    logic [utd_pkg::UNIT_W-1:0]  w_cont;

    always_comb begin
        w_acc  = i_state;
        w_emit = 1'b0;
        w_cont = '0;
        case (i_state.pend)
            utd_pkg::PEND_NONE: begin
                if (i_byte < utd_pkg::ASCII_LIMIT) begin
                    w_acc.acc  = {{(utd_pkg::UNIT_W-utd_pkg::BYTE_W){1'b0}}, i_byte};
                    w_emit     = 1'b1;
                end else if (i_byte < utd_pkg::THREE_BYTE_LEAD) begin
                    // Two-byte lead: five payload bits into [10:6]
                    w_acc.acc  = {5'b0, i_byte[4:0], 6'b0};
                    w_acc.pend = utd_pkg::PEND_ONE;
                end else begin
                    // Three-byte lead: four payload bits into [15:12]
                    w_acc.acc  = {i_byte[3:0], 12'b0};
                    w_acc.pend = utd_pkg::PEND_TWO;
                end
            end
            utd_pkg::PEND_ONE: begin
                w_cont     = {9'b0, i_byte[6:0]};
                w_acc.acc  = i_state.acc + w_cont;
                w_acc.pend = utd_pkg::PEND_NONE;
                w_emit     = 1'b1;
            end
            default: begin
                // Middle byte of a three-byte sequence; add shifted by six
                w_cont     = {3'b0, i_byte[6:0], 6'b0};
                w_acc.acc  = i_state.acc + w_cont;
                w_acc.pend = utd_pkg::PEND_ONE;
            end
        endcase
    end

    always_comb begin
        o_step.emit                = w_emit || i_last;
        o_step.res.code_unit       = w_acc.acc;
        o_step.res.stream_done     = i_last;
        o_step.res.truncated       = i_last && !w_emit;
        o_step.next                = w_acc;
        if (w_emit || i_last) begin
            // Clear the sequence once a unit leaves or the stream ends
            o_step.next.pend = utd_pkg::PEND_NONE;
            o_step.next.acc  = '0;
        end
    end

endmodule

// File: sv/utd_out_reg.sv
// ----------------------------------------------------------------------------
// utd_out_reg
// Result register: holds one code unit until the downstream side takes it.
// ----------------------------------------------------------------------------
module utd_out_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  utd_pkg::t_result             i_res,
    output logic                         o_free,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [utd_pkg::UNIT_W-1:0]   m_axis_tdata,   // [15:0] code_unit
    output logic                         m_axis_tlast,   // stream_done
    output logic [0:0]                   m_axis_tuser    // [0] truncated
);

    logic             r_vld;
    utd_pkg::t_result r_res;

    assign o_free = !r_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid   = r_vld;
    assign m_axis_tdata    = r_res.code_unit;
    assign m_axis_tlast    = r_res.stream_done;
    assign m_axis_tuser[0] = r_res.truncated;

endmodule

// File: sv/utf8_to_ucs2_decoder.sv
// Data path: a byte held in the input register is decoded combinationally; its code unit,
//   if it yields one, is loaded into the output register once that register is free.
// Throughput: one byte per cycle while the result register is free, through the combinational
//   decode step between the input register and the result register; a held result stalls the input.
// Reset (i_rst_n low, synchronous): both registers empty, no sequence open.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Streams UTF-8 bytes in and 16-bit UCS-2 code units out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_to_ucs2_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Byte stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [utd_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] byte_in
    input  logic                         s_axis_tlast,   // end_of_stream
    // Code unit stream out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [utd_pkg::UNIT_W-1:0]   m_axis_tdata,   // [15:0] code_unit
    output logic                         m_axis_tlast,   // stream_done
    output logic [0:0]                   m_axis_tuser    // [0] truncated
);

    // Held byte waiting for the decode step
    logic                        w_in_vld;
    logic [utd_pkg::BYTE_W-1:0]  w_in_byte;
    logic                        w_in_last;

    // Consume the held byte when it emits nothing, or the result slot is free
    logic                        w_pop;
    logic                        w_out_free;

    utd_pkg::t_state             r_state;
    utd_pkg::t_step              w_step;

    utd_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_pop         (w_pop),
        .o_vld         (w_in_vld),
        .o_byte        (w_in_byte),
        .o_last        (w_in_last)
    );

    utd_decode u_decode (
        .i_state (r_state),
        .i_byte  (w_in_byte),
        .i_last  (w_in_last),
        .o_step  (w_step)
    );

    assign w_pop = w_in_vld && (!w_step.emit || w_out_free);

    // Sequence state: advance only when a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pend <= utd_pkg::PEND_NONE;
            r_state.acc  <= '0;
        end else if (w_pop) begin
            r_state <= w_step.next;
        end
    end

    utd_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_pop && w_step.emit),
        .i_res         (w_step.res),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A pending count of three never arises
    `ASSERT_ALWAYS(a_pend_range, r_state.pend <= utd_pkg::PEND_TWO)
    // The final byte of a stream leaves no sequence open
    `ASSERT_NEXT(a_eos_clears, w_pop && w_in_last, r_state.pend == utd_pkg::PEND_NONE && r_state.acc == '0)
    // A truncated unit always closes its stream
    `ASSERT_ALWAYS(a_trunc_done, !(m_axis_tvalid && m_axis_tuser[0]) || m_axis_tlast)

endmodule

// File: bench/utf8_to_ucs2_decoder_test.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_test
// Streams UTF-8 words into the decoder and checks every UCS-2 code unit,
// its end-of-stream flag and its truncation flag against a decoder model
// held in the bench, or the row itself for typed table rows. A short
// table of hand-picked bytes runs first, then random sequences, mostly
// well formed, random gaps on both sides, one long output hold-off.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 900;   // random words after the table
    localparam int QUIET_FROM   = 820;   // random words sent before gaps stop
    localparam int HOLD_FROM    = 300;   // words sent before the long hold-off
    localparam int HOLD_CYCLES  = 48;    // length of the long hold-off
    localparam int DRAIN_CYCLES = 8;     // settle time after the last code unit

    typedef logic [utd_pkg::BYTE_W-1:0] t_byte;

    // One row of the directed table. Where typed is set, the code unit is
    // taken from the row; elsewhere the model supplies it.
    typedef struct packed {
        logic [utd_pkg::BYTE_W-1:0] byte_in;
        logic                       fin;
        logic                       typed;
        logic [utd_pkg::UNIT_W-1:0] code_unit;
        logic                       stream_done;
        logic                       truncated;
    } t_row;

    localparam int ROWS = 25;

    localparam t_row SCRIPT [ROWS] = '{
        // single bytes straight after reset, both ends of the range
        '{8'h00, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0},
        '{8'h7F, 1'b0, 1'b1, 16'h007F, 1'b0, 1'b0},
        '{8'h41, 1'b1, 1'b1, 16'h0041, 1'b1, 1'b0},
        // two-byte sequence, a stray continuation used as a lead, extremes
        '{8'hC2, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hA9, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hDF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        // three-byte sequences, lowest and one that wraps the accumulator
        '{8'hE0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        // stream ends on a lead byte: partial value, flagged truncated
        '{8'hE2, 1'b1, 1'b1, 16'h2000, 1'b1, 1'b1},
        '{8'hC3, 1'b1, 1'b1, 16'h00C0, 1'b1, 1'b1},
        // stream ends on the middle byte of a three-byte sequence
        '{8'hEF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hBF, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
        // stream ends on the byte that completes a sequence
        '{8'hC2, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hA9, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
        // ordinary three-byte character after a stream end
        '{8'hE4, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hB8, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{8'hAD, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        // lead byte above the three-byte range, ended at once
        '{8'hF5, 1'b1, 1'b1, 16'h5000, 1'b1, 1'b1}
    };

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [utd_pkg::BYTE_W-1:0] s_axis_tdata  = '0;   // [7:0] byte_in
    logic                       s_axis_tlast  = 1'b0; // end_of_stream
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [utd_pkg::UNIT_W-1:0] m_axis_tdata;         // [15:0] code_unit
    logic                       m_axis_tlast;         // stream_done
    logic [0:0]                 m_axis_tuser;         // [0] truncated

    // Decoder model state, advanced once per accepted word
    logic [utd_pkg::PEND_W-1:0] model_pend = utd_pkg::PEND_NONE;
    logic [utd_pkg::UNIT_W-1:0] model_acc  = '0;

    utd_pkg::t_result units_due [$];      // code units still to come, oldest first

    logic gaps_on      = 1'b1;   // random idling on both sides
    logic backpressure = 1'b0;   // long output hold-off
    int   sink_stall   = 0;
    int   bytes_sent   = 0;
    int   units_seen   = 0;
    int   ends_seen    = 0;
    int   truncs_seen  = 0;
    int   errors       = 0;

    utf8_to_ucs2_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the decoder model by one byte; return 1 when a code unit is due.
    function automatic logic decode_byte(input logic [utd_pkg::BYTE_W-1:0] b,
                                         input logic fin,
                                         output utd_pkg::t_result unit);
        logic complete;
        complete = 1'b0;
        case (model_pend)
            utd_pkg::PEND_NONE: begin
                if (b < utd_pkg::ASCII_LIMIT) begin
                    model_acc = {8'h00, b};
                    complete  = 1'b1;
                end else if (b < utd_pkg::THREE_BYTE_LEAD) begin
                    // two-byte lead: low five bits land in [10:6]
                    model_acc  = {5'b0, b[4:0], 6'b0};
                    model_pend = utd_pkg::PEND_ONE;
                end else begin
                    // three-byte lead: low nibble lands in [15:12]
                    model_acc  = {b[3:0], 12'h000};
                    model_pend = utd_pkg::PEND_TWO;
                end
            end
            utd_pkg::PEND_ONE: begin
                model_acc  = model_acc + {9'b0, b[6:0]};
                model_pend = utd_pkg::PEND_NONE;
                complete   = 1'b1;
            end
            default: begin
                // middle byte; the sum wraps at 16 bits
                model_acc  = model_acc + {3'b0, b[6:0], 6'b0};
                model_pend = utd_pkg::PEND_ONE;
            end
        endcase
        unit.code_unit   = model_acc;
        unit.stream_done = fin;
        unit.truncated   = fin && !complete;
        if (complete || fin) begin
            model_pend = utd_pkg::PEND_NONE;
            model_acc  = '0;
        end
        return complete || fin;
    endfunction

    // Offer one word, hold it until taken, then book its code unit if any.
    task automatic send_byte(input logic [utd_pkg::BYTE_W-1:0] b, input logic fin,
                             input logic typed, input utd_pkg::t_result typed_unit);
        utd_pkg::t_result unit;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (decode_byte(b, fin, unit))
            units_due.push_back(typed ? typed_unit : unit);
        bytes_sent++;
        // idle the input now and then, but keep feeding during the hold-off
        if (gaps_on && !backpressure && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Output ready: random stall bursts, plus the hold-off
    always @(posedge i_clk) begin
        if (sink_stall != 0) begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (backpressure) begin
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            sink_stall    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hold the output off long enough for the decoder to fill and stall its input
    initial begin : hold_off
        wait (bytes_sent >= HOLD_FROM);
        @(posedge i_clk);
        backpressure <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        backpressure <= 1'b0;
    end

    // Compare each code unit taken with the oldest one due
    always @(posedge i_clk) begin : unit_check
        utd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            units_seen++;
            if (m_axis_tlast) ends_seen++;
            if (m_axis_tuser[0]) truncs_seen++;
            if (units_due.size() == 0) begin
                $display("%0t: unexpected code unit, expected none, got %h last %b trunc %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                errors++;
            end else begin
                want = units_due.pop_front();
                if (m_axis_tdata !== want.code_unit) begin
                    $display("%0t: code unit mismatch, expected %h, got %h",
                             $time, want.code_unit, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.stream_done) begin
                    $display("%0t: stream end flag mismatch, expected %b, got %b",
                             $time, want.stream_done, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.truncated) begin
                    $display("%0t: truncation flag mismatch, expected %b, got %b",
                             $time, want.truncated, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        #200000;
        $display("Timed out with %0d code units outstanding", units_due.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        utd_pkg::t_result           row_unit;
        logic [utd_pkg::BYTE_W-1:0] seq [3];
        int                         seq_len;
        int                         kind;
        logic                       cut_short;
        int                         random_sent;

        // hold reset low from the start, then release once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < ROWS; r++) begin
            row_unit.code_unit   = SCRIPT[r].code_unit;
            row_unit.stream_done = SCRIPT[r].stream_done;
            row_unit.truncated   = SCRIPT[r].truncated;
            send_byte(SCRIPT[r].byte_in, SCRIPT[r].fin, SCRIPT[r].typed, row_unit);
        end

        // random sequences: mostly well formed, some noise and broken ends
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            kind      = $urandom_range(0, 9);
            cut_short = 1'b0;
            case (kind)
                0, 1, 2: begin
                    seq[0]  = t_byte'($urandom_range(8'h00, 8'h7F));
                    seq_len = 1;
                end
                3, 4: begin
                    seq[0]  = t_byte'($urandom_range(8'hC0, 8'hDF));
                    seq[1]  = t_byte'($urandom_range(8'h80, 8'hBF));
                    seq_len = 2;
                end
                5, 6: begin
                    seq[0]  = t_byte'($urandom_range(8'hE0, 8'hEF));
                    seq[1]  = t_byte'($urandom_range(8'h80, 8'hBF));
                    seq[2]  = t_byte'($urandom_range(8'h80, 8'hBF));
                    seq_len = 3;
                end
                7, 8: begin
                    // raw noise: any byte in any position
                    seq_len = $urandom_range(1, 3);
                    for (int k = 0; k < 3; k++) seq[k] = t_byte'($urandom_range(0, 255));
                end
                default: begin
                    // stream cut inside a sequence
                    seq[0]    = t_byte'($urandom_range(8'hC0, 8'hFF));
                    seq[1]    = t_byte'($urandom_range(8'h80, 8'hBF));
                    seq_len   = (seq[0] >= utd_pkg::THREE_BYTE_LEAD) ?
                                $urandom_range(1, 2) : 1;
                    cut_short = 1'b1;
                end
            endcase
            for (int k = 0; k < seq_len; k++) begin
                send_byte(seq[k],
                          (cut_short && k == seq_len - 1) || $urandom_range(0, 31) == 0,
                          1'b0, row_unit);
                random_sent++;
                if (random_sent == QUIET_FROM) gaps_on <= 1'b0;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain: wait for every code unit, then let the pipeline settle
        while (units_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d from the table) and checked %0d code units,",
                 bytes_sent, ROWS, units_seen);
        $display("%0d of them ending a stream and %0d flagged truncated.",
                 ends_seen, truncs_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/utd_pkg.sv
sv/utd_in_reg.sv
sv/utd_decode.sv
sv/utd_out_reg.sv
sv/utf8_to_ucs2_decoder.sv
bench/utf8_to_ucs2_decoder_test.sv
